/* hw/rtl/hias_pkg.sv */
// Shared types and constants for the hashed-index array shuffle.
package hias_pkg;

  localparam int unsigned MaxElementsDef = 1024;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PosW   = 10;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned HashW  = 32;

  localparam logic [CountW-1:0] CountRst = 11'd1024;

  // integer mix constants
  localparam logic [HashW-1:0] HashMul = 32'h7ed55d16;
  localparam logic [HashW-1:0] HashXor = 32'hc761c23c;
  localparam int unsigned      HashShl = 12;
  localparam int unsigned      HashShr = 19;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    WSRC_INPUT  = 2'd0,
    WSRC_PASS   = 2'd1,
    WSRC_TARGET = 2'd2
  } wsrc_e;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] word_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] word_out;
    logic                    run_done;
  } out_word_t;

  typedef struct packed {
    logic  rd_en;
    logic  rd_in;
    logic  mem_we;
    wsrc_e wsrc;
    logic  run_start;
    logic  pass_inc;
    logic  div_start;
    logic  out_load_read;
    logic  out_load_done;
  } hias_cmd_t;

  typedef struct packed {
    logic pass_lt_count;
    logic div_done;
  } hias_stat_t;

endpackage

/* hw/rtl/hias_rem.sv */
// Bit-serial remainder unit: 32-bit dividend by an 11-bit divisor.
module hias_rem import hias_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [HashW-1:0]  dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic [CountW-1:0] rem_o,
  output logic              done_o
);

  localparam int unsigned StepW = $clog2(HashW);

  logic [StepW-1:0]  step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [HashW-1:0]  dvd_q, dvd_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] dvs_q, dvs_d;
  logic [CountW:0]   trial, diff;
  logic              last;

  assign trial = {rem_q, dvd_q[HashW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign last  = (step_q == StepW'(HashW - 1));

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      step_d = '0;
      busy_d = 1'b1;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // restoring step: remainder stays below the divisor
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[CountW-1:0];
      end else begin
        rem_d = trial[CountW-1:0];
      end
      dvd_d  = {dvd_q[HashW-2:0], 1'b0};
      step_d = step_q + StepW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

/* hw/rtl/hias_dp.sv */
// Datapath: element store, count register, pass counter, hash and output word.
module hias_dp import hias_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  in_word_t          in_word_i,
  input  hias_cmd_t         cmd_i,
  output hias_stat_t        stat_o,
  output out_word_t         out_word_o
);

  localparam int unsigned AddrW = $clog2(MaxElements);

  logic [DataW-1:0]  mem_q [MaxElements];

  logic [CountW-1:0] cfg_count_q;
  logic [CountW-1:0] count_q, count_sat;
  logic [CountW-1:0] pass_q;
  logic [CountW-1:0] tgt_q, tgt;
  logic [HashW-1:0]  prod_q, mix;
  logic [CountW-1:0] rem;
  logic              div_done;
  logic [DataW-1:0]  rd_a_q, rd_b_q;
  logic              oob_q;
  logic              in_store;
  logic [AddrW-1:0]  rd_a_addr, rd_b_addr, wr_addr;
  logic [DataW-1:0]  wr_data;
  logic              wr_en;
  out_word_t         out_q;

  assign in_store  = (32'(in_word_i.position) < 32'(MaxElements));
  assign count_sat = (32'(cfg_count_q) > 32'(MaxElements)) ?
                     CountW'(MaxElements) : cfg_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= CountRst;
    end else if (cfg_we_i) begin
      cfg_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.run_start) begin
      pass_q  <= '0;
      count_q <= count_sat;
    end else if (cmd_i.pass_inc) begin
      pass_q  <= pass_q + CountW'(1);
    end
  end

  // first half of the mix: multiply-add, registered before the xor-shift
  always_ff @(posedge clk_i) begin
    prod_q <= (HashW'(pass_q) * HashMul) + (HashW'(pass_q) << HashShl);
  end

  assign mix = (prod_q ^ HashXor) ^ (prod_q >> HashShr);

  hias_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mix),
    .divisor_i  (count_q - pass_q),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  assign tgt = pass_q + rem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      tgt_q <= tgt;
    end
  end

  assign rd_a_addr = cmd_i.rd_in ? AddrW'(in_word_i.position) : AddrW'(pass_q);
  assign rd_b_addr = AddrW'(tgt);

  always_comb begin
    wr_en   = cmd_i.mem_we;
    wr_addr = AddrW'(pass_q);
    wr_data = rd_b_q;
    case (cmd_i.wsrc)
      WSRC_INPUT: begin
        wr_en   = cmd_i.mem_we && in_store;
        wr_addr = AddrW'(in_word_i.position);
        wr_data = in_word_i.word_in;
      end
      WSRC_PASS: begin
        wr_addr = AddrW'(pass_q);
        wr_data = rd_b_q;
      end
      WSRC_TARGET: begin
        wr_addr = AddrW'(tgt_q);
        wr_data = rd_a_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[rd_a_addr];
      rd_b_q <= mem_q[rd_b_addr];
      oob_q  <= cmd_i.rd_in && !in_store;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_read) begin
      out_q.word_out <= oob_q ? '0 : rd_a_q;
      out_q.run_done <= 1'b0;
    end else if (cmd_i.out_load_done) begin
      out_q.word_out <= '0;
      out_q.run_done <= 1'b1;
    end
  end

  assign stat_o.pass_lt_count = (pass_q < count_q);
  assign stat_o.div_done      = div_done;
  assign out_word_o           = out_q;

endmodule

/* hw/rtl/hias_ctrl.sv */
// Controller: sequences word acceptance, the shuffle pass and the output word.
module hias_ctrl import hias_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] in_kind_i,
  input  logic             out_stall_i,
  input  hias_stat_t       stat_i,
  output hias_cmd_t        cmd_o,
  output logic             in_stall_o,
  output logic             out_valid_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_READ   = 10'b00_0000_0010,
    S_NEXT   = 10'b00_0000_0100,
    S_HASH   = 10'b00_0000_1000,
    S_MIX    = 10'b00_0001_0000,
    S_DIV    = 10'b00_0010_0000,
    S_FETCH  = 10'b00_0100_0000,
    S_SWAP_P = 10'b00_1000_0000,
    S_SWAP_T = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{wsrc: WSRC_INPUT, default: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_WRITE: begin
              cmd_o.mem_we = 1'b1;
              cmd_o.wsrc   = WSRC_INPUT;
            end
            KIND_RUN: begin
              cmd_o.run_start = 1'b1;
              state_d         = S_NEXT;
            end
            KIND_READ: begin
              cmd_o.rd_en = 1'b1;
              cmd_o.rd_in = 1'b1;
              state_d     = S_READ;
            end
            default: begin
              // unused kind: word dropped
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.out_load_read = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_NEXT: begin
        state_d = stat_i.pass_lt_count ? S_HASH : S_DONE;
      end
      S_HASH: begin
        state_d = S_MIX;
      end
      S_MIX: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SWAP_P;
      end
      S_SWAP_P: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsrc   = WSRC_PASS;
        state_d      = S_SWAP_T;
      end
      S_SWAP_T: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.wsrc     = WSRC_TARGET;
        cmd_o.pass_inc = 1'b1;
        state_d        = S_NEXT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load_done = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load_read || cmd_o.out_load_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/hashed_index_array_shuffle.sv */
// Top level of the hashed-index in-place array shuffle.
//
//   port group   dir  handshake           payload
//   in           in   in_valid_i/stall_o  in_word_i  (kind, position, word_in)
//   out          out  out_valid_o/stall_i out_word_o (word_out, run_done)
//   cfg          in   cfg_we_i            cfg_data_i (element_count)
//
// Write word: one store write. Read word: store read, then output register.
// Run word: each position passes the hash, the bit-serial remainder unit, a fetch
// and two writes on the single store write port. Reset clears control only; store
// is unset until written.
// Input stalls while a read or run is in progress; a result waiting in the
// output register does not block write words.
module hashed_index_array_shuffle import hias_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o
);

  hias_cmd_t  cmd;
  hias_stat_t stat;

  hias_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_word_i.kind),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  hias_dp #(
    .MaxElements (MaxElements)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

/* test/tb_hashed_index_array_shuffle.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the hashed-index array shuffle: directed and random words against a predictor.
module tb_hashed_index_array_shuffle;
  import hias_pkg::*;

  localparam int unsigned StoreDepth   = MaxElementsDef;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 50;
  localparam int unsigned RandomWords  = 1650;
  localparam int unsigned IdlePct      = 13;

  localparam logic [KindW-1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic              is_cfg;
    logic              no_idle;
    logic [CountW-1:0] count;
    in_word_t          word;
  } bus_op_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_word_t          in_word_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_word_t         out_word_o;

  bus_op_t   pending_ops[$];
  out_word_t expected_words[$];
  int unsigned err_cnt = 0;

  // predictor state
  logic [DataW-1:0]  model_store [StoreDepth];
  logic [CountW-1:0] model_count = CountRst;

  // stimulus bookkeeping: which entries hold a written word
  bit                written [StoreDepth];
  bit                any_written = 1'b0;
  logic [CountW-1:0] gen_count   = CountRst;
  int unsigned       word_cnt    = 0;
  bit                calm_run    = 1'b0;

  logic [CountW-1:0] count_corners [6] = '{11'd1024, 11'd0, 11'd1, 11'd2047, 11'd2, 11'd1025};

  logic        no_idle_q  = 1'b0;
  int unsigned settle_cnt = 0;
  logic        nxt_valid;
  logic        nxt_we;
  out_word_t   exp_word;

  hashed_index_array_shuffle dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  function automatic logic [HashW-1:0] mix_hash(input logic [HashW-1:0] a);
    logic [HashW-1:0] h;
    h = (a * HashMul) + (a << HashShl);
    h = (h ^ HashXor) ^ (h >> HashShr);
    return h;
  endfunction

  // counts above the store size saturate
  function automatic int unsigned pass_span(input logic [CountW-1:0] c);
    return (int'(c) > StoreDepth) ? StoreDepth : int'(c);
  endfunction

  function automatic int unsigned swap_target(input int unsigned p, input int unsigned n);
    return p + (mix_hash(p) % (n - p));
  endfunction

  task automatic predict_word(input in_word_t w);
    int unsigned      n;
    int unsigned      t;
    logic [DataW-1:0] tmp;
    out_word_t        r;
    r = '0;
    case (w.kind)
      KIND_WRITE: begin
        if (w.position < StoreDepth) model_store[w.position] = w.word_in;
      end
      KIND_RUN: begin
        n = pass_span(model_count);
        for (int unsigned p = 0; p < n; p++) begin
          t = swap_target(p, n);
          tmp = model_store[p];
          model_store[p] = model_store[t];
          model_store[t] = tmp;
        end
        r.run_done = 1'b1;
        expected_words.push_back(r);
      end
      KIND_READ: begin
        r.word_out = (w.position < StoreDepth) ? model_store[w.position] : '0;
        expected_words.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic add_op(input logic [KindW-1:0] kind, input logic [PosW-1:0] pos,
                        input logic [DataW-1:0] val);
    bus_op_t     op;
    int unsigned n;
    int unsigned t;
    bit          f;
    op = '0;
    op.no_idle = calm_run;
    op.word.kind = kind;
    op.word.position = pos;
    op.word.word_in = val;
    pending_ops.push_back(op);
    if (kind == KIND_WRITE) begin
      written[pos] = 1'b1;
      any_written = 1'b1;
    end else if (kind == KIND_RUN) begin
      // unwritten entries travel with the shuffle too
      n = pass_span(gen_count);
      for (int unsigned p = 0; p < n; p++) begin
        t = swap_target(p, n);
        f = written[p];
        written[p] = written[t];
        written[t] = f;
      end
    end
    if (kind != KindUnused) word_cnt++;
  endtask

  task automatic add_count(input logic [CountW-1:0] c);
    bus_op_t op;
    op = '0;
    op.is_cfg = 1'b1;
    op.count = c;
    pending_ops.push_back(op);
    gen_count = c;
  endtask

  // mostly near the shuffled region so that reads see the passes
  function automatic logic [PosW-1:0] pick_pos();
    int unsigned hi;
    hi = pass_span(gen_count) + 8;
    if (hi > StoreDepth - 1) hi = StoreDepth - 1;
    if ($urandom_range(0, 4) != 0) return PosW'($urandom_range(0, hi));
    return PosW'($urandom_range(0, StoreDepth - 1));
  endfunction

  function automatic logic [PosW-1:0] pick_written();
    int unsigned     s;
    logic [PosW-1:0] p;
    for (int i = 0; i < 8; i++) begin
      p = pick_pos();
      if (written[p]) return p;
    end
    s = $urandom_range(0, StoreDepth - 1);
    for (int unsigned i = 0; i < StoreDepth; i++) begin
      if (written[(s + i) % StoreDepth]) return PosW'((s + i) % StoreDepth);
    end
    return '0;
  endfunction

  task automatic random_op(inout int unsigned runs_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_op(KindUnused, PosW'($urandom), $urandom);
    end else if (r < 12 && runs_left > 0) begin
      add_op(KIND_RUN, PosW'($urandom), $urandom);
      runs_left--;
    end else if (r < 55 || !any_written) begin
      add_op(KIND_WRITE, pick_pos(), $urandom);
    end else begin
      add_op(KIND_READ, pick_written(), $urandom);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(30_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cfg_we_i   <= 1'b0;
      no_idle_q  <= 1'b0;
      settle_cnt <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_word(in_word_i);
      nxt_valid = 1'b0;
      nxt_we    = 1'b0;
      if (in_valid_i && in_stall_o) begin
        nxt_valid = 1'b1;
      end else if (pending_ops.size() != 0 && pending_ops[0].is_cfg) begin
        // register only changes once the block has drained
        if (settle_cnt >= SettleCycles) begin
          nxt_we = 1'b1;
          cfg_data_i <= pending_ops[0].count;
          model_count = pending_ops[0].count;
          void'(pending_ops.pop_front());
        end
      end else if (pending_ops.size() != 0 &&
                   (pending_ops[0].no_idle || $urandom_range(0, 99) >= IdlePct)) begin
        nxt_valid = 1'b1;
        in_word_i <= pending_ops[0].word;
        no_idle_q <= pending_ops[0].no_idle;
        void'(pending_ops.pop_front());
      end
      in_valid_i <= nxt_valid;
      cfg_we_i   <= nxt_we;
      if (expected_words.size() != 0 || in_valid_i || cfg_we_i) settle_cnt <= 0;
      else if (settle_cnt < SettleCycles) settle_cnt <= settle_cnt + 1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: word_out %0d, run_done %0b",
                 out_word_o.word_out, out_word_o.run_done);
          err_cnt++;
        end else begin
          exp_word = expected_words.pop_front();
          if (out_word_o.word_out !== exp_word.word_out) begin
            $error("word_out: expected %0d, actual %0d", exp_word.word_out, out_word_o.word_out);
            err_cnt++;
          end
          if (out_word_o.run_done !== exp_word.run_done) begin
            $error("run_done: expected %0b, actual %0b", exp_word.run_done, out_word_o.run_done);
            err_cnt++;
          end
        end
      end
      out_stall_i <= !no_idle_q && ($urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin
    logic [CountW-1:0] c;
    int unsigned       runs_left;
    int unsigned       n_ops;
    int unsigned       phase_no;

    // directed: word extremes, ignored kind, reset count, count corners
    add_op(KIND_WRITE, 10'd0, 32'h8000_0000);
    add_op(KIND_WRITE, 10'd1, 32'h7fff_ffff);
    add_op(KIND_WRITE, 10'd2, 32'h0000_0000);
    add_op(KIND_WRITE, 10'd3, 32'hffff_ffff);
    add_op(KIND_WRITE, 10'h3ff, 32'h5a5a_a5a5);
    add_op(KindUnused, 10'h3ff, 32'hffff_ffff);
    add_op(KIND_READ, 10'h3ff, '0);
    add_op(KIND_READ, 10'd0, '0);
    add_op(KIND_READ, 10'd3, '0);
    add_op(KIND_RUN, 10'h3ff, 32'hffff_ffff);
    add_op(KIND_READ, pick_written(), '0);
    add_op(KIND_READ, pick_written(), '0);
    add_count(11'd4);
    add_op(KIND_RUN, '0, '0);
    add_op(KIND_READ, pick_written(), '0);
    add_op(KIND_READ, pick_written(), '0);
    add_count(11'd0);
    add_op(KIND_RUN, '0, '0);
    add_op(KIND_READ, pick_written(), '0);
    add_count(11'd1);
    add_op(KIND_RUN, '0, '0);
    add_op(KIND_READ, pick_written(), '0);
    add_count(11'd2047);
    add_op(KIND_RUN, '0, '0);
    add_op(KIND_READ, pick_written(), '0);
    add_op(KIND_READ, pick_written(), '0);

    word_cnt = 0;
    phase_no = 0;
    while (word_cnt < RandomWords) begin
      if (phase_no % 5 == 2) c = count_corners[(phase_no / 5) % 6];
      else c = CountW'($urandom_range(2, 48));
      add_count(c);
      runs_left = (pass_span(c) > 64) ? 1 : 1000;
      calm_run = (phase_no == 4);
      n_ops = $urandom_range(40, 120);
      for (int unsigned i = 0; i < n_ops; i++) random_op(runs_left);
      phase_no++;
    end
    calm_run = 1'b0;

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
